/* rtl/core/rtc_timestamp_with_calibration_defines.svh */
// assertion macros for the rtc timestamp block
// used by the top level; expects aclk and aresetn in scope
`ifndef RTC_TIMESTAMP_WITH_CALIBRATION_DEFINES_SVH
`define RTC_TIMESTAMP_WITH_CALIBRATION_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define RTC_TS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtc_ts check failed");

// next-cycle implication, checked out of reset
`define RTC_TS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtc_ts check failed");

`else

`define RTC_TS_ASSERT_NOW(label, ante, cons)
`define RTC_TS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/rtc_ts_pkg.sv */
// shared types and constants for the rtc timestamp block
// no dependencies; imported by rtc_ts_div and the top level
`default_nettype none

package rtc_ts_pkg;

    // widths
    localparam int TIMESTAMP_BITS_DEF = 48;
    localparam int TS_OUT_W   = 48;
    localparam int RATIO_W    = 11;
    localparam int DAY_MS_W   = 27;
    localparam int DAY_CNT_W  = 32;
    localparam int DAY_PROD_W = DAY_CNT_W + DAY_MS_W;
    localparam int FRAC_W     = 10;
    localparam int FRAC_NUM_W = 25;
    localparam int CAL_NUM_W  = 20;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = 7;
    localparam int SF_W       = 15;
    localparam int WIN_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // divide by 1000, one 16-bit digit per cycle by reciprocal multiply
    localparam int DIGIT_W     = 16;
    localparam int REM_W       = 10;
    localparam int DIG_NUM_W   = REM_W + DIGIT_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam int DIG_PROD_W  = DIG_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

    // time constants
    localparam logic [DAY_MS_W-1:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [DAY_MS_W-1:0] MS_PER_MIN  = 27'd60000;
    localparam logic [DAY_MS_W-1:0] MS_PER_SEC  = 27'd1000;
    localparam logic [DAY_MS_W-1:0] MS_PER_DAY  = 27'd86400000;

    // ratio limits, thousandths
    localparam logic [RATIO_W-1:0] RATIO_ONE = 11'd1000;
    localparam logic [RATIO_W-1:0] RATIO_MIN = 11'd600;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 11'd1400;

    // reset values of the config registers
    localparam logic [SF_W-1:0]  SF_RESET  = 15'd255;
    localparam logic [WIN_W-1:0] WIN_RESET = 10'd200;

    typedef enum logic {
        CMD_READ      = 1'b0,
        CMD_CALIBRATE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECOND_FRACTION = 1'b0,
        REG_CAL_WINDOW      = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_FRAC_WAIT,
        ST_DAY_MS,
        ST_DAY_MUL,
        ST_RAW,
        ST_CAL,
        ST_CAL_WAIT,
        ST_CAL_POST,
        ST_CORR_MUL,
        ST_CORR_DIV,
        ST_CORR_WAIT,
        ST_DONE
    } state_t;

    // divider request and status
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] len;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rtc_timestamp_with_calibration.sv */
// RTC millisecond timestamp with clock-ratio calibration.
// Input channel s_*: one item per request, valid/ready. command 0 reads the
// timestamp, command 1 calibrates from measured_elapsed_ms. Result channel
// m_*: exactly one item per input item, in order, valid/ready.
// Config port cfg_*: write second_fraction (index 0) or calibration_window_ms
// (index 1); write only while the block is idle.
// Datapath: a small sequencer runs around one shared restoring divider (one
// quotient bit per cycle) for the subsecond fraction and the ratio; the
// divide by 1000 of the correction takes one 16-bit digit per cycle.
// A raw read uses a 25-bit subsecond division, skipped when second_fraction
// is zero or below the subsecond count; a corrected read works at 48 bits;
// a calibration adds a 20-bit ratio division.
// Throughput: one item at a time; s_ready is high only when the sequencer is
// idle, from the cycle the result appears. The result sits in an output
// register, so the next item is accepted while an earlier result waits for
// m_ready; a stalled receiver holds the sequencer in its final step once a
// second result is ready.
// Reset: synchronous, active low; clears day count, calibration, ratio
// (back to 1000), offset and restores the config reset values.
// depends on rtc_ts_pkg, rtc_ts_div and the assertion macro header
`default_nettype none

`include "rtc_timestamp_with_calibration_defines.svh"

module rtc_timestamp_with_calibration
    import rtc_ts_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [4:0]            s_hours,
    input  wire logic [5:0]            s_minutes,
    input  wire logic [5:0]            s_seconds,
    input  wire logic [14:0]           s_subsecond_count,
    input  wire logic                  s_apply_correction,
    input  wire logic [15:0]           s_measured_elapsed_ms,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [TS_OUT_W-1:0]        m_timestamp_ms,
    output logic [RATIO_W-1:0]         m_current_ratio,
    output logic                       m_ratio_rejected
);

    localparam int TS_W     = TIMESTAMP_BITS;
    localparam int DW       = TIMESTAMP_BITS + RATIO_W;
    localparam int CHUNKS   = (DW + DIGIT_W - 1) / DIGIT_W;
    localparam int PW       = CHUNKS * DIGIT_W;
    localparam int CH_CNT_W = $clog2(CHUNKS + 1);

    // control state
    state_t                state_reg, state_next;
    logic [SF_W-1:0]       sf_reg, sf_next;
    logic [WIN_W-1:0]      win_reg, win_next;
    logic [DAY_CNT_W-1:0]  day_count_reg, day_count_next;
    logic [DAY_MS_W-1:0]   last_day_ms_reg, last_day_ms_next;
    logic                  calibrated_reg, calibrated_next;
    logic [RATIO_W-1:0]    clock_ratio_reg, clock_ratio_next;
    logic [TS_W-1:0]       time_offset_reg, time_offset_next;
    logic                  m_valid_reg, m_valid_next;

    // payload and working registers
    cmd_t                  cmd_reg, cmd_next;
    logic [4:0]            hours_reg, hours_next;
    logic [5:0]            minutes_reg, minutes_next;
    logic [5:0]            seconds_reg, seconds_next;
    logic [14:0]           ss_reg, ss_next;
    logic                  apply_reg, apply_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic [DAY_MS_W-1:0]   day_ms_reg, day_ms_next;
    logic [DAY_PROD_W-1:0] day_prod_reg, day_prod_next;
    logic [TS_W-1:0]       ts_reg, ts_next;
    logic [TS_W-1:0]       raw_reg, raw_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [PW-1:0]         cq_reg, cq_next;
    logic [REM_W-1:0]      crem_reg, crem_next;
    logic [CH_CNT_W-1:0]   chunk_cnt_reg, chunk_cnt_next;
    logic [RATIO_W-1:0]    new_ratio_reg, new_ratio_next;
    logic                  rejected_reg, rejected_next;
    logic [TS_OUT_W-1:0]   m_ts_reg, m_ts_next;
    logic [RATIO_W-1:0]    m_ratio_reg, m_ratio_next;
    logic                  m_rej_reg, m_rej_next;

    // shared divider
    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [FRAC_NUM_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [FRAC_NUM_W-1:0] div_quot;

    // datapath helpers
    logic                  frac_skip;
    logic [FRAC_NUM_W-1:0] frac_num;
    logic [CAL_NUM_W-1:0]  cal_num;
    logic [CAL_NUM_W-1:0]  cal_q;
    logic [FRAC_W-1:0]     frac;
    logic [DAY_MS_W-1:0]   day_ms;
    logic [63:0]           raw_sum;
    logic [DIG_NUM_W-1:0]  dig_num;
    logic [DIG_PROD_W-1:0] dig_prod;
    logic [DIGIT_W-1:0]    dig_q;
    logic [REM_W-1:0]      dig_rem;

    rtc_ts_div #(
        .DVD_W (FRAC_NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // operands of the arithmetic steps
    always_comb begin
        frac_skip = (sf_reg == '0) || (ss_reg > sf_reg);
        frac_num  = FRAC_NUM_W'(sf_reg - ss_reg) * FRAC_NUM_W'(MS_PER_SEC);
        cal_num   = CAL_NUM_W'(win_reg) * CAL_NUM_W'(MS_PER_SEC);
        cal_q     = div_quot[CAL_NUM_W-1:0];
        frac      = frac_skip ? '0 : div_quot[FRAC_W-1:0];
        day_ms    = DAY_MS_W'(hours_reg) * MS_PER_HOUR
                  + DAY_MS_W'(minutes_reg) * MS_PER_MIN
                  + DAY_MS_W'(seconds_reg) * MS_PER_SEC
                  + DAY_MS_W'(frac) + DAY_MS_W'(1);
        raw_sum   = 64'(day_prod_reg) + 64'(day_ms_reg);
        // one digit of the divide by 1000, remainder carried to the next
        dig_num   = {crem_reg, prod_reg[PW-1 -: DIGIT_W]};
        dig_prod  = DIG_PROD_W'(dig_num) * DIG_PROD_W'(RECIP_1000);
        dig_q     = dig_prod[RECIP_SHIFT +: DIGIT_W];
        dig_rem   = REM_W'(dig_num - DIG_NUM_W'(dig_q) * DIG_NUM_W'(MS_PER_SEC));
    end

    // divider operand select, dividend left aligned to its length
    always_comb begin
        case (state_reg)
            ST_FRAC: begin
                div_dividend = frac_num;
                div_divisor  = DIVISOR_W'(sf_reg);
            end
            ST_CAL: begin
                div_dividend = FRAC_NUM_W'(cal_num) << (FRAC_NUM_W - CAL_NUM_W);
                div_divisor  = elapsed_reg;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb begin
        state_next       = state_reg;
        sf_next          = sf_reg;
        win_next         = win_reg;
        day_count_next   = day_count_reg;
        last_day_ms_next = last_day_ms_reg;
        calibrated_next  = calibrated_reg;
        clock_ratio_next = clock_ratio_reg;
        time_offset_next = time_offset_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        cmd_next         = cmd_reg;
        hours_next       = hours_reg;
        minutes_next     = minutes_reg;
        seconds_next     = seconds_reg;
        ss_next          = ss_reg;
        apply_next       = apply_reg;
        elapsed_next     = elapsed_reg;
        day_ms_next      = day_ms_reg;
        day_prod_next    = day_prod_reg;
        ts_next          = ts_reg;
        raw_next         = raw_reg;
        prod_next        = prod_reg;
        cq_next          = cq_reg;
        crem_next        = crem_reg;
        chunk_cnt_next   = chunk_cnt_reg;
        new_ratio_next   = new_ratio_reg;
        rejected_next    = rejected_reg;
        m_ts_next        = m_ts_reg;
        m_ratio_next     = m_ratio_reg;
        m_rej_next       = m_rej_reg;
        div_req          = '0;

        // config writes
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_SECOND_FRACTION: sf_next  = cfg_wdata[SF_W-1:0];
                REG_CAL_WINDOW:      win_next = cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next      = cmd_t'(s_command);
                    hours_next    = s_hours;
                    minutes_next  = s_minutes;
                    seconds_next  = s_seconds;
                    ss_next       = s_subsecond_count;
                    apply_next    = s_apply_correction;
                    elapsed_next  = s_measured_elapsed_ms;
                    rejected_next = 1'b0;
                    state_next    = ST_FRAC;
                end
            end
            // subsecond fraction, skipped when second_fraction is zero or below the subsecond count
            ST_FRAC: begin
                if (frac_skip) begin
                    state_next = ST_DAY_MS;
                end else begin
                    div_req.start = 1'b1;
                    div_req.len   = DIV_CNT_W'(FRAC_NUM_W);
                    state_next    = ST_FRAC_WAIT;
                end
            end
            ST_FRAC_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_DAY_MS;
                end
            end
            // ms in day and rollover detection
            ST_DAY_MS: begin
                day_ms_next      = day_ms;
                last_day_ms_next = day_ms;
                if (day_ms < last_day_ms_reg) begin
                    day_count_next = day_count_reg + 1'b1;
                end
                state_next = ST_DAY_MUL;
            end
            ST_DAY_MUL: begin
                day_prod_next = DAY_PROD_W'(day_count_reg) * DAY_PROD_W'(MS_PER_DAY);
                state_next    = ST_RAW;
            end
            ST_RAW: begin
                raw_next = raw_sum[TS_W-1:0];
                ts_next  = raw_sum[TS_W-1:0];
                if (cmd_reg == CMD_CALIBRATE) begin
                    state_next = ST_CAL;
                end else if (apply_reg && calibrated_reg) begin
                    state_next = ST_CORR_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            // ratio = window * 1000 / elapsed
            ST_CAL: begin
                if (elapsed_reg == '0) begin
                    new_ratio_next = RATIO_ONE;
                    rejected_next  = 1'b1;
                    state_next     = ST_CAL_POST;
                end else begin
                    div_req.start = 1'b1;
                    div_req.len   = DIV_CNT_W'(CAL_NUM_W);
                    state_next    = ST_CAL_WAIT;
                end
            end
            ST_CAL_WAIT: begin
                if (div_stat.done) begin
                    if (cal_q > CAL_NUM_W'(RATIO_MAX) || cal_q < CAL_NUM_W'(RATIO_MIN)) begin
                        new_ratio_next = RATIO_ONE;
                        rejected_next  = 1'b1;
                    end else begin
                        new_ratio_next = cal_q[RATIO_W-1:0];
                    end
                    state_next = ST_CAL_POST;
                end
            end
            ST_CAL_POST: begin
                state_next = calibrated_reg ? ST_CORR_MUL : ST_DONE;
            end
            // correction: floor(raw * ratio / 1000) + offset
            ST_CORR_MUL: begin
                prod_next      = PW'(raw_reg) * PW'(clock_ratio_reg);
                crem_next      = '0;
                chunk_cnt_next = CH_CNT_W'(CHUNKS);
                state_next     = ST_CORR_DIV;
            end
            // divide by 1000, top digit first
            ST_CORR_DIV: begin
                crem_next      = dig_rem;
                cq_next        = {cq_reg[PW-DIGIT_W-1:0], dig_q};
                prod_next      = {prod_reg[PW-DIGIT_W-1:0], DIGIT_W'(0)};
                chunk_cnt_next = chunk_cnt_reg - 1'b1;
                if (chunk_cnt_reg == CH_CNT_W'(1)) begin
                    state_next = ST_CORR_WAIT;
                end
            end
            ST_CORR_WAIT: begin
                ts_next    = cq_reg[TS_W-1:0] + time_offset_reg;
                state_next = ST_DONE;
            end
            // hand the item to the output register and commit calibration
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ts_next    = TS_OUT_W'(ts_reg);
                    m_rej_next   = rejected_reg;
                    if (cmd_reg == CMD_CALIBRATE) begin
                        m_ratio_next     = new_ratio_reg;
                        clock_ratio_next = new_ratio_reg;
                        calibrated_next  = 1'b1;
                        if (calibrated_reg) begin
                            time_offset_next = ts_reg;
                            day_count_next   = '0;
                            last_day_ms_next = '0;
                        end else begin
                            time_offset_next = '0;
                        end
                    end else begin
                        m_ratio_next = clock_ratio_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sf_reg          <= SF_RESET;
            win_reg         <= WIN_RESET;
            day_count_reg   <= '0;
            last_day_ms_reg <= '0;
            calibrated_reg  <= 1'b0;
            clock_ratio_reg <= RATIO_ONE;
            time_offset_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sf_reg          <= sf_next;
            win_reg         <= win_next;
            day_count_reg   <= day_count_next;
            last_day_ms_reg <= last_day_ms_next;
            calibrated_reg  <= calibrated_next;
            clock_ratio_reg <= clock_ratio_next;
            time_offset_reg <= time_offset_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        hours_reg     <= hours_next;
        minutes_reg   <= minutes_next;
        seconds_reg   <= seconds_next;
        ss_reg        <= ss_next;
        apply_reg     <= apply_next;
        elapsed_reg   <= elapsed_next;
        day_ms_reg    <= day_ms_next;
        day_prod_reg  <= day_prod_next;
        ts_reg        <= ts_next;
        raw_reg       <= raw_next;
        prod_reg      <= prod_next;
        cq_reg        <= cq_next;
        crem_reg      <= crem_next;
        chunk_cnt_reg <= chunk_cnt_next;
        new_ratio_reg <= new_ratio_next;
        rejected_reg  <= rejected_next;
        m_ts_reg      <= m_ts_next;
        m_ratio_reg   <= m_ratio_next;
        m_rej_reg     <= m_rej_next;
    end

    // ports
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_timestamp_ms   = m_ts_reg;
    assign m_current_ratio  = m_ratio_reg;
    assign m_ratio_rejected = m_rej_reg;

    // checks
    `RTC_TS_ASSERT_NOW(a_ratio_low, 1'b1, clock_ratio_reg >= RATIO_MIN)
    `RTC_TS_ASSERT_NOW(a_ratio_high, 1'b1, clock_ratio_reg <= RATIO_MAX)
    `RTC_TS_ASSERT_NOW(a_reject_gives_one, m_valid_reg && m_rej_reg, m_ratio_reg == RATIO_ONE)
    `RTC_TS_ASSERT_NOW(a_div_start_idle, div_req.start, !div_stat.busy)
    `RTC_TS_ASSERT_NEXT(a_calibrated_sticks, calibrated_reg, calibrated_reg)

endmodule

`default_nettype wire

/* rtl/core/rtc_ts_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on rtc_ts_pkg; dividend is left aligned by the caller
`default_nettype none

module rtc_ts_div
    import rtc_ts_pkg::*;
#(
    parameter int DVD_W = TIMESTAMP_BITS_DEF + RATIO_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire div_req_t             req,
    input  wire logic [DVD_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output div_stat_t                 stat,
    output logic [DVD_W-1:0]          quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic                 qbit;

    // one restoring step
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    // sequencing of the iterations
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = req.len;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

`default_nettype wire
